>>> rtl/core/spsc_pkg.sv
// Shared constants for the smoothed PD steering controller.
// Field widths, datapath widths and configuration register indexes.
// No dependencies.
package spsc_pkg;

	// Field and register widths
	localparam int ANGLE_W  = 16;
	localparam int STEER_W  = 16;
	localparam int ALPHA_W  = 9;
	localparam int GAIN_W   = 12;
	localparam int LIMIT_W  = 15;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Internal state widths
	localparam int SMOOTH_W = 24;
	localparam int INTEG_W  = 32;
	localparam int ACC_W    = 48;

	// Shift-add multiplier: one multiplier bit per cycle
	localparam int MUL_STEPS = 12;
	localparam int CNT_W     = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTRE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd6;

	// Register reset values
	localparam logic [ALPHA_W-1:0]          ALPHA_RST    = 9'd192;
	localparam logic [GAIN_W-1:0]           GAIN_P_RST   = 12'd179;
	localparam logic [GAIN_W-1:0]           GAIN_I_RST   = 12'd0;
	localparam logic [GAIN_W-1:0]           GAIN_D_RST   = 12'd205;
	localparam logic signed [STEER_W-1:0]   CENTRE_RST   = 16'sd98;
	localparam logic [LIMIT_W-1:0]          LIMIT_RST    = 15'd1280;
	localparam logic [LIMIT_W-1:0]          DEADBAND_RST = 15'd256;

endpackage

>>> rtl/core/smoothed_pd_steering_controller_unit.sv
// Smoothed PD steering controller, top level; depends on spsc_pkg.
// One angle sample in, one steering command out, over a bit-serial shift-add datapath.
// Steps: smoothing pass, integral update, integral-gain pass, clamp, P pass, D pass, final.
// A new sample is taken only after the last is through four 12-step passes of the shared multiplier.
// The next sample is taken while a finished result still waits in the output register.
// Reset (arst_n low): registers to defaults, filter and integral state to zero, no result.
module smoothed_pd_steering_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [spsc_pkg::ANGLE_W-1:0] angle_sample,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [spsc_pkg::STEER_W-1:0] steering_value
);
	import spsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SMOOTH,
		ST_INTEG,
		ST_MUL_I,
		ST_CLAMP,
		ST_MUL_P,
		ST_MUL_D,
		ST_FINAL
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_STEPS - 1);
	localparam logic signed [SMOOTH_W-1:0] Q_MAX = 24'sd32767;
	localparam logic signed [SMOOTH_W-1:0] Q_MIN = -24'sd32768;

	// Configuration registers
	logic [ALPHA_W-1:0]        alpha_q;
	logic [GAIN_W-1:0]         gain_p_q;
	logic [GAIN_W-1:0]         gain_i_q;
	logic [GAIN_W-1:0]         gain_d_q;
	logic signed [STEER_W-1:0] centre_q;
	logic [LIMIT_W-1:0]        limit_q;
	logic [LIMIT_W-1:0]        deadband_q;

	// Controller state
	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SMOOTH_W-1:0] smooth_q;
	logic signed [SMOOTH_W-1:0] prev_q;
	logic signed [INTEG_W-1:0]  integral_q;
	logic                       dead_q;

	// Shift-add multiplier registers
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mcand_q;
	logic [GAIN_W-1:0]       mplier_q;

	// Result register
	logic                       out_valid_q;
	logic signed [STEER_W-1:0]  result_q;

	// Datapath helpers
	logic [ALPHA_W-1:0]         alpha_eff;
	logic signed [SMOOTH_W:0]   diff_in;
	logic signed [SMOOTH_W-1:0] smooth_new;
	logic signed [INTEG_W:0]    integ_sum;
	logic signed [INTEG_W-1:0]  integ_sat;
	logic signed [SMOOTH_W:0]   smooth_ext;
	logic signed [SMOOTH_W:0]   db_pos;
	logic signed [SMOOTH_W:0]   db_neg;
	logic                       in_dead;
	logic signed [ACC_W-1:0]    lim_pos;
	logic signed [ACC_W-1:0]    lim_neg;
	logic                       clear_integ;
	logic signed [SMOOTH_W:0]   diff_d;
	logic signed [ACC_W-1:0]    final_x;
	logic signed [SMOOTH_W-1:0] quot_floor;
	logic signed [SMOOTH_W-1:0] quot_trunc;
	logic signed [STEER_W-1:0]  pid_result;
	logic                       mul_last;
	logic                       in_xfer;
	logic                       out_free;

	assign cfg_ready      = 1'b1;
	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = out_valid_q;
	assign steering_value = result_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign mul_last = (cnt_q == CNT_LAST);

	// Alpha above one acts as one
	assign alpha_eff = alpha_q[ALPHA_W-1] ? {1'b1, {(ALPHA_W-1){1'b0}}} : alpha_q;

	// Smoothing is rewritten as sample*2^16 + alpha*(smoothed - sample*2^8),
	// so one multiply by alpha does the whole convex combination.
	assign diff_in = {smooth_q[SMOOTH_W-1], smooth_q}
		- {angle_sample[ANGLE_W-1], angle_sample, 8'b0};

	// End of smoothing: floor divide by 256 is the arithmetic shift
	assign smooth_new = acc_q[SMOOTH_W+7:8];

	// Integral with saturation at the 32-bit bounds
	assign integ_sum = {integral_q[INTEG_W-1], integral_q}
		+ {{(INTEG_W-SMOOTH_W+1){smooth_new[SMOOTH_W-1]}}, smooth_new};
	always_comb begin
		case (integ_sum[INTEG_W:INTEG_W-1])
			2'b01:   integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
			2'b10:   integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
			default: integ_sat = integ_sum[INTEG_W-1:0];
		endcase
	end

	// Deadband: strictly inside plus or minus deadband*256
	assign smooth_ext = {smooth_new[SMOOTH_W-1], smooth_new};
	assign db_pos     = {2'b00, deadband_q, 8'b0};
	assign db_neg     = -db_pos;
	assign in_dead    = (smooth_ext > db_neg) && (smooth_ext < db_pos);

	// Integral clear: gain_i*integral strictly outside plus or minus limit*2^16
	assign lim_pos     = {{(ACC_W-LIMIT_W-16){1'b0}}, limit_q, 16'b0};
	assign lim_neg     = -lim_pos;
	assign clear_integ = (acc_q > lim_pos) || (acc_q < lim_neg);

	// Derivative operand
	assign diff_d = {smooth_q[SMOOTH_W-1], smooth_q} - {prev_q[SMOOTH_W-1], prev_q};

	// Final: centre*2^24 minus the PID sum, truncated toward zero, saturated
	assign final_x    = {{(ACC_W-STEER_W-24){centre_q[STEER_W-1]}}, centre_q, 24'b0} - acc_q;
	assign quot_floor = final_x[ACC_W-1:24];
	assign quot_trunc = (final_x[ACC_W-1] && (final_x[23:0] != 24'b0))
		? quot_floor + 24'sd1 : quot_floor;
	always_comb begin
		if (quot_trunc > Q_MAX) begin
			pid_result = 16'sh7FFF;
		end else if (quot_trunc < Q_MIN) begin
			pid_result = -16'sh8000;
		end else begin
			pid_result = quot_trunc[STEER_W-1:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= ALPHA_RST;
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
			centre_q   <= CENTRE_RST;
			limit_q    <= LIMIT_RST;
			deadband_q <= DEADBAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ALPHA:    alpha_q    <= cfg_data[ALPHA_W-1:0];
				REG_GAIN_P:   gain_p_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:   gain_i_q   <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:   gain_d_q   <= cfg_data[GAIN_W-1:0];
				REG_CENTRE:   centre_q   <= cfg_data;
				REG_LIMIT:    limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_DEADBAND: deadband_q <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			smooth_q    <= '0;
			prev_q      <= '0;
			integral_q  <= '0;
			dead_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			result_q    <= '0;
		end else begin
			// drop the result once its transfer completes, unless the next one lands now
			if (out_valid_q && out_ready && (state_q != ST_FINAL)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						acc_q    <= {{(ACC_W-ANGLE_W-16){angle_sample[ANGLE_W-1]}},
							angle_sample, 16'b0};
						mcand_q  <= {{(ACC_W-SMOOTH_W-1){diff_in[SMOOTH_W]}}, diff_in};
						mplier_q <= {{(GAIN_W-ALPHA_W){1'b0}}, alpha_eff};
						cnt_q    <= '0;
						state_q  <= ST_SMOOTH;
					end
				end

				ST_SMOOTH, ST_MUL_I, ST_MUL_P, ST_MUL_D: begin
					// one multiplier bit per cycle: add, then advance the operands
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					if (mul_last && (state_q == ST_MUL_P)) begin
						// load the derivative pass, sum keeps accumulating
						mcand_q  <= {{(ACC_W-SMOOTH_W-1){diff_d[SMOOTH_W]}}, diff_d};
						mplier_q <= gain_d_q;
					end else begin
						mcand_q  <= mcand_q <<< 1;
						mplier_q <= mplier_q >> 1;
					end
					if (mul_last) begin
						cnt_q <= '0;
						case (state_q)
							ST_SMOOTH: state_q <= ST_INTEG;
							ST_MUL_I:  state_q <= ST_CLAMP;
							ST_MUL_P:  state_q <= ST_MUL_D;
							default:   state_q <= ST_FINAL;
						endcase
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end

				ST_INTEG: begin
					smooth_q   <= smooth_new;
					integral_q <= integ_sat;
					dead_q     <= in_dead;
					acc_q      <= '0;
					mcand_q    <= {{(ACC_W-INTEG_W){integ_sat[INTEG_W-1]}}, integ_sat};
					mplier_q   <= gain_i_q;
					cnt_q      <= '0;
					state_q    <= ST_MUL_I;
				end

				ST_CLAMP: begin
					// a cleared integral contributes nothing to the sum
					if (clear_integ) begin
						integral_q <= '0;
						acc_q      <= '0;
					end
					mcand_q  <= {{(ACC_W-SMOOTH_W){smooth_q[SMOOTH_W-1]}}, smooth_q};
					mplier_q <= gain_p_q;
					cnt_q    <= '0;
					state_q  <= ST_MUL_P;
				end

				ST_FINAL: begin
					// hold until the output register is free
					if (out_free) begin
						result_q    <= dead_q ? centre_q : pid_result;
						out_valid_q <= 1'b1;
						prev_q      <= smooth_q;
						state_q     <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
